### sv/hcba_pkg.sv
// Shared types and constants for the heap card barrier allocator.
// No dependencies; the other files except hcba_ram refer to it by scoped names.
package hcba_pkg;

    localparam int CFG_W   = 31;
    localparam int CELL_W  = 30;
    localparam int COUNT_W = 21;

    typedef enum logic [2:0] {
        CMD_MARK    = 3'd0,
        CMD_QUERY   = 3'd1,
        CMD_ALLOC   = 3'd2,
        CMD_RESERVE = 3'd3,
        CMD_SET_PTR = 3'd4
    } t_cmd;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_NOROOM = 2'd1;
    localparam logic [1:0] STS_RANGE  = 2'd2;

    localparam logic [2:0] REG_OLD_BASE    = 3'd0;
    localparam logic [2:0] REG_OLD_END     = 3'd1;
    localparam logic [2:0] REG_NEW_START   = 3'd2;
    localparam logic [2:0] REG_ALLOC_LIMIT = 3'd3;
    localparam logic [2:0] REG_HEAP_BASE   = 3'd4;
    localparam logic [2:0] REG_HEAP_END    = 3'd5;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [CELL_W-1:0]  cell_addr;
        logic [COUNT_W-1:0] cell_count;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic              in_old;
        logic              in_new;
        logic              in_heap;
        logic              card_set;
        logic [CELL_W-1:0] alloc_addr;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_WBACK
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic calc;
        logic read;
        logic wback;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
    } t_dp_sts;

endpackage

### sv/hcba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hcba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/hcba_ctrl.sv
// Sequencing state machine: card store clearing pass, then one item per pass
// through calc, card read and write-back. Uses hcba_pkg.
module hcba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hcba_pkg::t_dp_sts i_sts,
    output hcba_pkg::t_dp_cmd o_cmd,
    output logic              o_busy
);

    hcba_pkg::t_state r_state;
    hcba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hcba_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            hcba_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = hcba_pkg::ST_IDLE;
                end
            end
            hcba_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = hcba_pkg::ST_CALC;
                end
            end
            hcba_pkg::ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = hcba_pkg::ST_READ;
            end
            hcba_pkg::ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = hcba_pkg::ST_WBACK;
            end
            hcba_pkg::ST_WBACK: begin
                o_cmd.wback = 1'b1;
                n_state     = hcba_pkg::ST_IDLE;
            end
            default: begin
                n_state = hcba_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

### sv/hcba_dp.sv
// Datapath: configuration registers, allocation pointer, range compares,
// card store (hcba_ram) read-modify-write and result register. Uses hcba_pkg.
module hcba_dp #(
    parameter int CARD_WORDS = 4096,
    parameter int ADDR_BITS  = 30
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hcba_pkg::t_dp_cmd           i_cmd,
    output hcba_pkg::t_dp_sts           o_sts,
    input  hcba_pkg::t_in_item          i_item,
    input  logic                        i_cfg_we,
    input  logic [2:0]                  i_cfg_index,
    input  logic [hcba_pkg::CFG_W-1:0]  i_cfg_data,
    output hcba_pkg::t_out_item         o_result,
    output logic                        o_strobe
);

    localparam int IDX_W = (CARD_WORDS > 1) ? $clog2(CARD_WORDS) : 1;
    localparam int SUM_W = ((ADDR_BITS > hcba_pkg::CFG_W) ? ADDR_BITS : hcba_pkg::CFG_W) + 1;
    localparam int WORD_W = hcba_pkg::CELL_W - 6;
    localparam logic [WORD_W-1:0] CARD_WORDS_W = WORD_W'(CARD_WORDS);
    localparam logic [IDX_W-1:0]  CLR_LAST     = IDX_W'(CARD_WORDS - 1);

    logic [hcba_pkg::CFG_W-1:0] r_old_base, r_old_end, r_new_start;
    logic [hcba_pkg::CFG_W-1:0] r_alloc_limit, r_heap_base, r_heap_end;
    logic [ADDR_BITS-1:0]       r_ptr;
    logic [ADDR_BITS-1:0]       n_ptr;
    logic [IDX_W-1:0]           r_clr_cnt;

    logic [2:0]                    r_cmd;
    logic [hcba_pkg::CELL_W-1:0]   r_addr;
    logic [hcba_pkg::COUNT_W-1:0]  r_count;

    logic                          r_in_old, r_in_new, r_in_heap, r_fits;
    logic [hcba_pkg::CELL_W-1:0]   r_off;
    logic [SUM_W-1:0]              r_sum;

    hcba_pkg::t_out_item r_res;
    hcba_pkg::t_out_item n_res;
    logic                r_strobe;

    // combinational helpers
    logic [SUM_W-1:0] addr_x, sum_x;
    logic             is_mark, is_query, range_ok, bit_now;
    logic [63:0]      rdata, bit_mask;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [63:0]      ram_wdata;
    logic [IDX_W-1:0] card_idx;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_base    <= '0;
            r_old_end     <= '0;
            r_new_start   <= '0;
            r_alloc_limit <= '0;
            r_heap_base   <= '0;
            r_heap_end    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hcba_pkg::REG_OLD_BASE:    r_old_base    <= i_cfg_data;
                hcba_pkg::REG_OLD_END:     r_old_end     <= i_cfg_data;
                hcba_pkg::REG_NEW_START:   r_new_start   <= i_cfg_data;
                hcba_pkg::REG_ALLOC_LIMIT: r_alloc_limit <= i_cfg_data;
                hcba_pkg::REG_HEAP_BASE:   r_heap_base   <= i_cfg_data;
                hcba_pkg::REG_HEAP_END:    r_heap_end    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end
    assign o_sts.clear_last = (r_clr_cnt == CLR_LAST);

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_item.cmd;
            r_addr  <= i_item.cell_addr;
            r_count <= i_item.cell_count;
        end
    end

    // classification and bump sum
    assign addr_x = SUM_W'(r_addr);
    assign sum_x  = SUM_W'(r_ptr) + SUM_W'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_in_old  <= (addr_x >= SUM_W'(r_old_base)) && (addr_x < SUM_W'(r_old_end));
            r_in_new  <= (addr_x >= SUM_W'(r_new_start)) && (addr_x < SUM_W'(r_ptr));
            r_in_heap <= (addr_x >= SUM_W'(r_heap_base)) && (addr_x < SUM_W'(r_heap_end));
            r_off     <= r_addr - hcba_pkg::CELL_W'(r_old_base);
            r_sum     <= sum_x;
        end
    end

    // fit check on the registered sum, ready by write-back
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_fits <= (r_sum < SUM_W'(r_alloc_limit))
                   && ((r_sum >> ADDR_BITS) == '0);
        end
    end

    assign card_idx = r_off[6 +: IDX_W];

    hcba_ram #(
        .WIDTH(64),
        .DEPTH(CARD_WORDS)
    ) u_card_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.read),
        .i_raddr (card_idx),
        .o_rdata (rdata)
    );

    always_comb begin
        is_mark  = (r_cmd == hcba_pkg::CMD_MARK);
        is_query = (r_cmd == hcba_pkg::CMD_QUERY);
        range_ok = (r_off[hcba_pkg::CELL_W-1:6] < CARD_WORDS_W);
        bit_mask = 64'd1 << r_off[5:0];
        bit_now  = rdata[r_off[5:0]];

        ram_we    = 1'b0;
        ram_waddr = card_idx;
        ram_wdata = rdata | bit_mask;
        if (i_cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt;
            ram_wdata = '0;
        end else if (i_cmd.wback && is_mark && r_in_old && range_ok) begin
            ram_we = 1'b1;
        end

        n_res = '0;
        n_ptr = r_ptr;
        case (r_cmd)
            hcba_pkg::CMD_MARK, hcba_pkg::CMD_QUERY: begin
                n_res.in_old  = r_in_old;
                n_res.in_new  = r_in_new;
                n_res.in_heap = r_in_heap;
                if (r_in_old) begin
                    if (range_ok) begin
                        n_res.card_set = is_mark | bit_now;
                    end else begin
                        n_res.status = hcba_pkg::STS_RANGE;
                    end
                end
            end
            hcba_pkg::CMD_ALLOC: begin
                if (r_fits) begin
                    n_res.alloc_addr = hcba_pkg::CELL_W'(r_ptr);
                    n_ptr            = r_sum[ADDR_BITS-1:0];
                end else begin
                    n_res.status = hcba_pkg::STS_NOROOM;
                end
            end
            hcba_pkg::CMD_RESERVE: begin
                n_res.status = r_fits ? hcba_pkg::STS_OK : hcba_pkg::STS_NOROOM;
            end
            hcba_pkg::CMD_SET_PTR: begin
                n_ptr = ADDR_BITS'(r_addr);
            end
            default: ;
        endcase
        // query reads the card bit only; a mark result is set when the cell is in the old range and card range
        if (!(is_mark || is_query)) begin
            n_res.card_set = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.wback;
            if (i_cmd.wback) begin
                r_ptr <= n_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wback) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;
    assign o_strobe = r_strobe;

endmodule

### sv/heap_card_barrier_allocator.sv
// Heap card barrier allocator, top level: joins controller and datapath.
// Depends on hcba_pkg, hcba_ctrl, hcba_dp (and hcba_ram beneath it).
//
// After reset the block clears its card store, one word a cycle, which keeps
// busy high until every word is cleared; configuration writes are taken
// during that time. Then each command is accepted when start is high and
// busy is low, and its result appears on o_result with o_strobe high for one
// cycle, after the command has passed the calc, read and write-back states.
// The receiver cannot stall the block. A new command may be accepted at the
// edge that ends the cycle its predecessor's result is shown, not before. The
// steps are: register the operands, compare and subtract, read the card word
// from the card RAM (registered read), then merge and write it back. Writing
// new_start does not move the allocation pointer; use the set-pointer command.
module heap_card_barrier_allocator #(
    parameter int CARD_WORDS = 4096,
    parameter int ADDR_BITS  = 30
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  hcba_pkg::t_in_item          i_item,
    output hcba_pkg::t_out_item         o_result,
    output logic                        o_strobe,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [2:0]                  i_cfg_index,
    input  logic [hcba_pkg::CFG_W-1:0]  i_cfg_data
);

    hcba_pkg::t_dp_cmd dp_cmd;
    hcba_pkg::t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    hcba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    hcba_dp #(
        .CARD_WORDS (CARD_WORDS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

endmodule
